// ===== src/assert_macros.svh =====
// assertion macros used by the upscaler's top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define S2X_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define S2X_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define S2X_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/s2x_pkg.sv =====
// shared types, constants and the scale2x corner rule
package s2x_pkg;

    localparam int X_BITS    = 10;
    localparam int Y_BITS    = 12;
    localparam int WORD_BITS = 32;
    localparam int CFG_BITS  = 13;

    // configuration register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [10:0] WIDTH_RESET  = 11'd1024;
    localparam logic [12:0] HEIGHT_RESET = 13'd1024;
    localparam logic [12:0] HEIGHT_LIMIT = 13'd4096;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        word_t tl;
        word_t tr;
        word_t bl;
        word_t br;
    } quad_t;

    typedef struct packed {
        logic [X_BITS-1:0] src_x;
        logic [Y_BITS-1:0] src_y;
        word_t             top_left;
        word_t             top_right;
        word_t             bottom_left;
        word_t             bottom_right;
        logic              run_last;
        logic              frame_done;
    } result_t;

    typedef struct packed {
        logic can_take;
        logic not_empty;
    } queue_status_t;

    // last row index from a raw height register value
    function automatic logic [Y_BITS-1:0] height_last_of(input logic [CFG_BITS-1:0] raw);
        logic [CFG_BITS-1:0] h;
        h = raw;
        if (h == '0) h = CFG_BITS'(1);
        if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
        return Y_BITS'(h - CFG_BITS'(1));
    endfunction

    // scale2x rule, a neighbour flagged absent never matches
    function automatic quad_t scale2x(input word_t b, input logic hb, input word_t d,
                                      input logic hd, input word_t e, input word_t f,
                                      input logic hf, input word_t h, input logic hh);
        logic  bd;
        logic  bf;
        logic  dh;
        logic  fh;
        quad_t q;
        bd = hb && hd && (b == d);
        bf = hb && hf && (b == f);
        dh = hd && hh && (d == h);
        fh = hf && hh && (f == h);
        q.tl = (bd && !bf && !dh) ? d : e;
        q.tr = (bf && !bd && !fh) ? f : e;
        q.bl = (dh && !bd && !fh) ? d : e;
        q.br = (fh && !dh && !bf) ? f : e;
        return q;
    endfunction

endpackage

// ===== src/s2x_line_mem.sv =====
// two-bank line store, one write port and two registered read ports
module s2x_line_mem #(
    parameter int DW = 32,
    parameter int AW = 11
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [DW-1:0] rd_data_a,
    output logic [DW-1:0] rd_data_b
);

    localparam int DEPTH = 1 << AW;

    logic [DW-1:0] mem [DEPTH];

    // write-first forwarding on a same-address read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem[rd_addr_a];
        rd_data_b <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem[rd_addr_b];
    end

endmodule

// ===== src/s2x_out_queue.sv =====
// four-entry result queue taking up to three results per cycle
module s2x_out_queue (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [2:0]                push_valid,
    input  s2x_pkg::result_t [2:0]    push_items,
    input  logic                      pop,
    output s2x_pkg::result_t          head,
    output s2x_pkg::queue_status_t    status
);

    s2x_pkg::result_t entry_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] off [3];
    logic [1:0] idx [3];
    logic [1:0] pushes;

    always_comb begin
        off[0] = 2'd0;
        off[1] = {1'b0, push_valid[0]};
        off[2] = {1'b0, push_valid[0]} + {1'b0, push_valid[1]};
        for (int k = 0; k < 3; k++) begin
            idx[k] = wr_ptr_reg + off[k];
        end
        pushes      = off[2] + {1'b0, push_valid[2]};
        wr_ptr_next = wr_ptr_reg + pushes;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, pushes} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            if (push_valid[k]) begin
                entry_reg[idx[k]] <= push_items[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head             = entry_reg[rd_ptr_reg];
    assign status.can_take  = (count_reg <= 3'd1);
    assign status.not_empty = (count_reg != 3'd0);

endmodule

// ===== src/scale2x_pixel_upscaler_unit.sv =====
// top level of the scale2x pixel upscaler
// Scale2x (EPX) upscaler. Source pixels enter in raster order, one request per
// pixel, and each source pixel E leaves as a 2x2 block tagged with its source
// column and row. A block is sent once its lower neighbour has arrived, so rows
// lag one source row behind the input; on the last row each pixel also closes
// the block to its left, and the last pixel of that row its own block, which
// gives up to three results per request. run_last marks the last result of a
// request, frame_done the block of the frame's final pixel. The rows above
// live in a two-bank line store with registered reads, prefetched from the next
// counter values so that a pixel can enter on every clock while the queue has
// room; a 4-entry result queue parts the two sides. Rate: one pixel per cycle
// while the queue holds at most one result; on the last row of a frame two or
// more rows tall each pixel past column 0 gives two or more results and the
// output port (one result a cycle) sets the pace. No clearing pass after reset.
// Any configuration write restarts the frame at row 0, column 0.
`include "assert_macros.svh"

module scale2x_pixel_upscaler_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    // source pixel channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_pixel,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [9:0]  m_src_x,
    output logic [11:0] m_src_y,
    output logic [31:0] m_top_left,
    output logic [31:0] m_top_right,
    output logic [31:0] m_bottom_left,
    output logic [31:0] m_bottom_right,
    output logic        m_run_last,
    output logic        m_frame_done
);

    // column counter width and width-compare width
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
    localparam int YB = s2x_pkg::Y_BITS;
    localparam int WB = s2x_pkg::WORD_BITS;

    // last column index from a raw width register value
    function automatic logic [CW-1:0] width_last_of(input logic [10:0] raw);
        logic [WW-1:0] w;
        w = WW'(raw);
        if (w == '0) w = WW'(1);
        if (w > WW'(MAX_WIDTH)) w = WW'(MAX_WIDTH);
        return CW'(w - WW'(1));
    endfunction

    // frame geometry, stored as last indexes
    logic [CW-1:0] wlast_reg;
    logic [YB-1:0] hlast_reg;

    // raster position of the pixel on the input
    logic [CW-1:0] col_reg, col_next;
    logic [YB-1:0] row_reg, row_next;

    // current row history: two pixels back and the row's first pixel
    logic [PIXEL_BITS-1:0] prev_reg, prev_next;
    logic [PIXEL_BITS-1:0] pprev_reg, pprev_next;
    logic [PIXEL_BITS-1:0] first_reg, first_next;

    // row above: window at columns c and c-1
    logic [PIXEL_BITS-1:0] e_win_reg, e_win_next;
    logic [PIXEL_BITS-1:0] d_win_reg, d_win_next;

    logic [PIXEL_BITS-1:0] pix;
    logic [PIXEL_BITS-1:0] rd_f;     // row above, column c+1
    logic [PIXEL_BITS-1:0] rd_b;     // two rows above, column c
    logic [CW:0]           rd_addr_a;
    logic [CW:0]           rd_addr_b;
    logic [CW:0]           wr_addr;

    logic acc;
    logic col_is_last;
    logic row_is_last;
    logic [2:0] blk_valid;
    s2x_pkg::quad_t q1, q2, q3;
    s2x_pkg::result_t [2:0] blk;
    s2x_pkg::result_t head;
    s2x_pkg::queue_status_t q_status;

    assign pix         = s_pixel[PIXEL_BITS-1:0];
    assign acc         = s_valid && s_ready;
    assign s_ready     = q_status.can_take;
    assign col_is_last = (col_reg == wlast_reg);
    assign row_is_last = (row_reg == hlast_reg);

    // which blocks this pixel completes
    assign blk_valid[0] = (row_reg != '0);
    assign blk_valid[1] = row_is_last && (col_reg != '0);
    assign blk_valid[2] = row_is_last && col_is_last;

    // centre (c, r-1): b two rows up, h is the incoming pixel
    assign q1 = s2x_pkg::scale2x(WB'(rd_b), row_reg > YB'(1), WB'(d_win_reg), col_reg != '0,
                                 WB'(e_win_reg), WB'(rd_f), !col_is_last, WB'(pix), 1'b1);
    // centre (c-1, r) on the last row
    assign q2 = s2x_pkg::scale2x(WB'(d_win_reg), row_reg != '0, WB'(pprev_reg),
                                 col_reg > CW'(1), WB'(prev_reg), WB'(pix), 1'b1,
                                 '0, 1'b0);
    // centre (c, r) at the end of the last row
    assign q3 = s2x_pkg::scale2x(WB'(e_win_reg), row_reg != '0, WB'(prev_reg), col_reg != '0,
                                 WB'(pix), '0, 1'b0, '0, 1'b0);

    always_comb begin
        blk[0].src_x        = s2x_pkg::X_BITS'(col_reg);
        blk[0].src_y        = row_reg - YB'(1);
        blk[0].top_left     = q1.tl;
        blk[0].top_right    = q1.tr;
        blk[0].bottom_left  = q1.bl;
        blk[0].bottom_right = q1.br;
        blk[0].run_last     = !blk_valid[1] && !blk_valid[2];
        blk[0].frame_done   = 1'b0;

        blk[1].src_x        = s2x_pkg::X_BITS'(col_reg - CW'(1));
        blk[1].src_y        = row_reg;
        blk[1].top_left     = q2.tl;
        blk[1].top_right    = q2.tr;
        blk[1].bottom_left  = q2.bl;
        blk[1].bottom_right = q2.br;
        blk[1].run_last     = !blk_valid[2];
        blk[1].frame_done   = 1'b0;

        blk[2].src_x        = s2x_pkg::X_BITS'(col_reg);
        blk[2].src_y        = row_reg;
        blk[2].top_left     = q3.tl;
        blk[2].top_right    = q3.tr;
        blk[2].bottom_left  = q3.bl;
        blk[2].bottom_right = q3.br;
        blk[2].run_last     = 1'b1;
        blk[2].frame_done   = 1'b1;
    end

    // position and window update
    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        prev_next  = prev_reg;
        pprev_next = pprev_reg;
        first_next = first_reg;
        e_win_next = e_win_reg;
        d_win_next = d_win_reg;
        if (cfg_we) begin
            // any register write restarts the frame
            col_next   = '0;
            row_next   = '0;
            prev_next  = '0;
            pprev_next = '0;
        end else if (acc) begin
            if (col_reg == '0) begin
                first_next = pix;
            end
            if (col_is_last) begin
                col_next   = '0;
                row_next   = row_is_last ? '0 : row_reg + YB'(1);
                prev_next  = '0;
                pprev_next = '0;
                // next row sees this row, starting at its column 0
                e_win_next = (col_reg == '0) ? pix : first_reg;
            end else begin
                col_next   = col_reg + CW'(1);
                prev_next  = pix;
                pprev_next = prev_reg;
                d_win_next = e_win_reg;
                e_win_next = rd_f;
            end
        end
    end

    // prefetch for the pixel that will be current next cycle
    assign rd_addr_a = {~row_next[0], CW'(col_next + CW'(1))};
    assign rd_addr_b = {row_next[0], col_next};
    assign wr_addr   = {row_reg[0], col_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlast_reg <= width_last_of(s2x_pkg::WIDTH_RESET);
            hlast_reg <= s2x_pkg::height_last_of(s2x_pkg::HEIGHT_RESET);
            col_reg   <= '0;
            row_reg   <= '0;
            prev_reg  <= '0;
            pprev_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    s2x_pkg::CFG_IMAGE_WIDTH: begin
                        wlast_reg <= width_last_of(cfg_data[10:0]);
                    end
                    s2x_pkg::CFG_IMAGE_HEIGHT: begin
                        hlast_reg <= s2x_pkg::height_last_of(cfg_data);
                    end
                    default: begin
                    end
                endcase
            end
            col_reg   <= col_next;
            row_reg   <= row_next;
            prev_reg  <= prev_next;
            pprev_reg <= pprev_next;
        end
    end

    // window payload, no reset needed
    always_ff @(posedge aclk) begin
        first_reg <= first_next;
        e_win_reg <= e_win_next;
        d_win_reg <= d_win_next;
    end

    // line store: bank = row parity, write current pixel, read rows above
    s2x_line_mem #(
        .DW (PIXEL_BITS),
        .AW (CW + 1)
    ) u_line_mem (
        .aclk      (aclk),
        .wr_en     (acc),
        .wr_addr   (wr_addr),
        .wr_data   (pix),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_f),
        .rd_data_b (rd_b)
    );

    // result queue, compacts the blocks of one request in order
    s2x_out_queue u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (acc ? blk_valid : 3'b000),
        .push_items (blk),
        .pop        (m_valid && m_ready),
        .head       (head),
        .status     (q_status)
    );

    assign m_valid        = q_status.not_empty;
    assign m_src_x        = head.src_x;
    assign m_src_y        = head.src_y;
    assign m_top_left     = head.top_left;
    assign m_top_right    = head.top_right;
    assign m_bottom_left  = head.bottom_left;
    assign m_bottom_right = head.bottom_right;
    assign m_run_last     = head.run_last;
    assign m_frame_done   = head.frame_done;

    // final pixel of the frame wraps the raster position
    `S2X_ASSERT_NEXT(a_frame_wrap, aclk, aresetn, acc && col_is_last && row_is_last, (col_reg == '0) && (row_reg == '0), "frame end did not wrap position")
    // a request below the first row always yields a result
    `S2X_ASSERT_NEXT(a_row_emits, aclk, aresetn, acc && (row_reg != '0), m_valid, "request below first row produced no result")
    // the frame's last block closes its request
    `S2X_ASSERT_SAME(a_done_last, aclk, aresetn, m_valid && m_frame_done, m_run_last, "frame_done without run_last")
    // input is never taken without room for three results
    `S2X_ASSERT_ALWAYS(a_room, aclk, aresetn, !acc || q_status.can_take, "request taken with full queue")

endmodule

// ===== tb/scale2x_pixel_upscaler_unit_tb.sv =====
// self-checking testbench for the scale2x pixel upscaler, with its own block predictor
module scale2x_pixel_upscaler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_COLS    = 1024;   // widest row the block holds
    localparam int FRAME_ROWS    = 4096;   // tallest frame
    localparam int SETTLE_CYCLES = 20;     // covers a request still in flight with no block out
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
    localparam int STALL_LIMIT   = 2000;   // cycles with no request moving on either side
    localparam int RANDOM_PIXELS = 140;
    localparam int REPORT_LIMIT  = 10;

    typedef enum logic { ROW_WRITE, ROW_PIXEL } row_kind_t;

    // one line of the directed table; typed rows carry their block written out by hand
    typedef struct {
        row_kind_t          kind;
        logic               reg_idx;
        logic [12:0]        reg_val;
        s2x_pkg::word_t     pixel;
        bit                 typed;
        s2x_pkg::result_t   want;
    } plan_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [12:0] cfg_data  = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [31:0] s_pixel   = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [9:0]  m_src_x;
    logic [11:0] m_src_y;
    logic [31:0] m_top_left;
    logic [31:0] m_top_right;
    logic [31:0] m_bottom_left;
    logic [31:0] m_bottom_right;
    logic        m_run_last;
    logic        m_frame_done;

    // predictor state: two row banks by row parity, raster position, last two pixels
    s2x_pkg::word_t   line_mem [2*FRAME_COLS];
    logic [10:0]      width_reg;
    logic [12:0]      height_reg;
    int unsigned      col_pos;
    int unsigned      row_pos;
    s2x_pkg::word_t   left_pix;
    s2x_pkg::word_t   left2_pix;

    s2x_pkg::result_t blocks_due[$];     // expected blocks, oldest first
    s2x_pkg::result_t step_blocks[$];    // blocks completed by the pixel just predicted
    plan_row_t        plan[$];
    s2x_pkg::word_t   palette [4];
    int unsigned      palette_n;
    int          mismatches  = 0;
    int unsigned rx_max      = 0;   // receiver pause ceiling, set with nba by the sender
    int unsigned hold_ask    = 0;   // bumped by the sender to ask for a hold-off
    int unsigned hold_seen   = 0;
    int unsigned hold_left   = 0;
    int unsigned rx_wait     = 0;
    int unsigned idle_cycles = 0;

    scale2x_pixel_upscaler_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel       (s_pixel),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_src_x       (m_src_x),
        .m_src_y       (m_src_y),
        .m_top_left    (m_top_left),
        .m_top_right   (m_top_right),
        .m_bottom_left (m_bottom_left),
        .m_bottom_right(m_bottom_right),
        .m_run_last    (m_run_last),
        .m_frame_done  (m_frame_done)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // width and height as the block uses them: zero acts as one, too large is clipped
    function automatic int unsigned cols_in_use();
        if (width_reg == '0) return 1;
        if (width_reg > FRAME_COLS) return FRAME_COLS;
        return int'(width_reg);
    endfunction

    function automatic int unsigned rows_in_use();
        if (height_reg == '0) return 1;
        if (height_reg > FRAME_ROWS) return FRAME_ROWS;
        return int'(height_reg);
    endfunction

    function automatic void restart_counts();
        col_pos   = 0;
        row_pos   = 0;
        left_pix  = '0;
        left2_pix = '0;
    endfunction

    function automatic int unsigned pause_len(int unsigned top);
        return (top == 0) ? 0 : $urandom_range(0, top);
    endfunction

    // one 2x2 block around mid; an absent neighbour never matches anything
    function automatic s2x_pkg::result_t epx_block(int unsigned x, int unsigned y,
                                          s2x_pkg::word_t up, bit has_up,
                                          s2x_pkg::word_t lf, bit has_lf,
                                          s2x_pkg::word_t mid, s2x_pkg::word_t rt,
                                          bit has_rt, s2x_pkg::word_t dn, bit has_dn,
                                          bit last_px);
        bit               up_lf;
        bit               up_rt;
        bit               lf_dn;
        bit               rt_dn;
        s2x_pkg::result_t blk;
        up_lf = has_up && has_lf && (up == lf);
        up_rt = has_up && has_rt && (up == rt);
        lf_dn = has_lf && has_dn && (lf == dn);
        rt_dn = has_rt && has_dn && (rt == dn);
        blk.src_x        = s2x_pkg::X_BITS'(x);
        blk.src_y        = s2x_pkg::Y_BITS'(y);
        blk.top_left     = (up_lf && !up_rt && !lf_dn) ? lf : mid;
        blk.top_right    = (up_rt && !up_lf && !rt_dn) ? rt : mid;
        blk.bottom_left  = (lf_dn && !up_lf && !rt_dn) ? lf : mid;
        blk.bottom_right = (rt_dn && !lf_dn && !up_rt) ? rt : mid;
        blk.run_last     = 1'b0;
        blk.frame_done   = last_px;
        return blk;
    endfunction

    // advance the predictor by one pixel, leaving the finished blocks in step_blocks
    function automatic void predict_pixel(s2x_pkg::word_t p);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned cur;
        int unsigned prv;
        w = cols_in_use();
        h = rows_in_use();
        c = col_pos;
        r = row_pos;
        step_blocks.delete();
        if (c >= w) c = 0;
        if (r >= h) r = 0;
        cur = r % 2;
        prv = (r + 1) % 2;
        // this pixel is the lower neighbour of the centre right above it
        if (r >= 1) begin
            step_blocks.push_back(epx_block(c, r - 1,
                (r >= 2) ? line_mem[cur*FRAME_COLS + c] : '0, r >= 2,
                (c >= 1) ? line_mem[prv*FRAME_COLS + c - 1] : '0, c >= 1,
                line_mem[prv*FRAME_COLS + c],
                (c + 1 < w) ? line_mem[prv*FRAME_COLS + c + 1] : '0, c + 1 < w,
                p, 1'b1, 1'b0));
        end
        // bottom row: close the centre to the left, and at row end this one too
        if (r == h - 1) begin
            if (c >= 1) begin
                step_blocks.push_back(epx_block(c - 1, r,
                    (r >= 1) ? line_mem[prv*FRAME_COLS + c - 1] : '0, r >= 1,
                    left2_pix, c >= 2, left_pix, p, 1'b1, '0, 1'b0, 1'b0));
            end
            if (c == w - 1) begin
                step_blocks.push_back(epx_block(c, r,
                    (r >= 1) ? line_mem[prv*FRAME_COLS + c] : '0, r >= 1,
                    left_pix, c >= 1, p, '0, 1'b0, '0, 1'b0, 1'b1));
            end
        end
        line_mem[cur*FRAME_COLS + c] = p;
        left2_pix = left_pix;
        left_pix  = p;
        c++;
        if (c >= w) begin
            c         = 0;
            left_pix  = '0;
            left2_pix = '0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
        if (step_blocks.size() != 0) step_blocks[step_blocks.size() - 1].run_last = 1'b1;
    endfunction

    function automatic void plan_add(row_kind_t kind, logic idx, logic [12:0] val,
                                     s2x_pkg::word_t pix, bit typed);
        plan_row_t row;
        row.kind    = kind;
        row.reg_idx = idx;
        row.reg_val = val;
        row.pixel   = pix;
        row.typed   = typed;
        // a lone pixel in a 1x1 frame comes back unchanged in all four corners
        row.want    = '{src_x: '0, src_y: '0, top_left: pix, top_right: pix,
                        bottom_left: pix, bottom_right: pix, run_last: 1'b1,
                        frame_done: 1'b1};
        plan.push_back(row);
    endfunction

    function automatic void new_palette();
        palette_n = $urandom_range(2, 4);
        foreach (palette[i]) palette[i] = $urandom;
    endfunction

    // mostly palette colors so that neighbours match, now and then any word
    function automatic s2x_pkg::word_t pick_pixel();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return palette[$urandom_range(0, palette_n - 1)];
    endfunction

    // compare one accepted block with the oldest expectation
    function automatic void check_block();
        s2x_pkg::result_t got;
        s2x_pkg::result_t want;
        got.src_x        = m_src_x;
        got.src_y        = m_src_y;
        got.top_left     = m_top_left;
        got.top_right    = m_top_right;
        got.bottom_left  = m_bottom_left;
        got.bottom_right = m_bottom_right;
        got.run_last     = m_run_last;
        got.frame_done   = m_frame_done;
        if (blocks_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("unexpected block: x=%0d y=%0d", got.src_x, got.src_y);
            return;
        end
        want = blocks_due.pop_front();
        if (got.src_x !== want.src_x || got.src_y !== want.src_y ||
            got.top_left !== want.top_left || got.top_right !== want.top_right ||
            got.bottom_left !== want.bottom_left || got.bottom_right !== want.bottom_right ||
            got.run_last !== want.run_last || got.frame_done !== want.frame_done) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("block mismatch: expected x=%0d y=%0d %h %h %h %h last=%b done=%b",
                         want.src_x, want.src_y, want.top_left, want.top_right,
                         want.bottom_left, want.bottom_right, want.run_last,
                         want.frame_done);
                $display("                actual   x=%0d y=%0d %h %h %h %h last=%b done=%b",
                         got.src_x, got.src_y, got.top_left, got.top_right,
                         got.bottom_left, got.bottom_right, got.run_last, got.frame_done);
            end
        end
    endfunction

    // receiver: pause after each block, plus the long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_block();
                rx_wait = pause_len(rx_max);
            end
            if (hold_ask != hold_seen) begin
                hold_seen = hold_ask;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog: too long with no request moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // wait until every expected block is out, then let a silent request drain
    task automatic settle();
        s_valid <= 1'b0;
        while (blocks_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register write; any write also restarts the frame
    task automatic write_reg(logic idx, logic [12:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (idx == s2x_pkg::CFG_IMAGE_WIDTH) width_reg = val[10:0];
        else height_reg = val;
        restart_counts();
    endtask

    task automatic resize(bit do_w, logic [12:0] w_raw, bit do_h, logic [12:0] h_raw);
        settle();
        if (do_w) write_reg(s2x_pkg::CFG_IMAGE_WIDTH, w_raw);
        if (do_h) write_reg(s2x_pkg::CFG_IMAGE_HEIGHT, h_raw);
    endtask

    // one pixel request: gap, then valid held until the block takes it
    task automatic feed(s2x_pkg::word_t p, int unsigned gap, bit typed,
                        s2x_pkg::result_t want);
        predict_pixel(p);
        if (typed) blocks_due.push_back(want);
        else foreach (step_blocks[i]) blocks_due.push_back(step_blocks[i]);
        repeat (gap) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= p;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin
        // two 3x3 frames: the first copies into top left and bottom right,
        // the second into top right and bottom left
        s2x_pkg::word_t frame_pair [18] = '{
            32'd9, 32'd2, 32'd9,  32'd2, 32'd7, 32'd4,  32'd9, 32'd4, 32'd9,
            32'd9, 32'd2, 32'd9,  32'd3, 32'd7, 32'd2,  32'd9, 32'd3, 32'd9};
        int unsigned tx_max;
        int unsigned fed;
        int unsigned n;
        int unsigned frame_px;
        int unsigned which;
        logic [12:0] w_raw;
        logic [12:0] h_raw;

        width_reg  = s2x_pkg::WIDTH_RESET;
        height_reg = s2x_pkg::HEIGHT_RESET;
        restart_counts();

        // directed table
        // reset size: two pixels on row 0 complete nothing
        plan_add(ROW_PIXEL, s2x_pkg::CFG_IMAGE_WIDTH, '0, 32'h0000_0001, 1'b0);
        plan_add(ROW_PIXEL, s2x_pkg::CFG_IMAGE_WIDTH, '0, 32'h8000_0000, 1'b0);
        // zero width and height act as a 1x1 frame
        plan_add(ROW_WRITE, s2x_pkg::CFG_IMAGE_WIDTH, 13'd0, '0, 1'b0);
        plan_add(ROW_WRITE, s2x_pkg::CFG_IMAGE_HEIGHT, 13'd0, '0, 1'b0);
        plan_add(ROW_PIXEL, s2x_pkg::CFG_IMAGE_WIDTH, '0, 32'h0000_0000, 1'b1);
        plan_add(ROW_PIXEL, s2x_pkg::CFG_IMAGE_WIDTH, '0, 32'hFFFF_FFFF, 1'b1);
        plan_add(ROW_PIXEL, s2x_pkg::CFG_IMAGE_WIDTH, '0, 32'h5555_5555, 1'b1);
        plan_add(ROW_PIXEL, s2x_pkg::CFG_IMAGE_WIDTH, '0, 32'hAAAA_AAAA, 1'b1);
        // 3x3 frames back to back, the second starts from the frame wrap
        plan_add(ROW_WRITE, s2x_pkg::CFG_IMAGE_WIDTH, 13'd3, '0, 1'b0);
        plan_add(ROW_WRITE, s2x_pkg::CFG_IMAGE_HEIGHT, 13'd3, '0, 1'b0);
        foreach (frame_pair[i])
            plan_add(ROW_PIXEL, s2x_pkg::CFG_IMAGE_WIDTH, '0, frame_pair[i], 1'b0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        rx_max <= 2;
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                feed(plan[i].pixel, $urandom_range(0, 2), plan[i].typed, plan[i].want);
            end
        end

        // width above the limit is clipped to 1024, single-row frame, first pixels only
        resize(1'b1, 13'h07FF, 1'b1, 13'd1);
        new_palette();
        rx_max <= 3;
        repeat (24) feed(pick_pixel(), pause_len(1), 1'b0, '0);

        // largest legal sizes, a few pixels on row 0 only, then cut by a write
        resize(1'b1, 13'd1024, 1'b1, 13'd4096);
        repeat (20) feed(pick_pixel(), pause_len(7), 1'b0, '0);

        // height above the limit, narrow rows, partial frame
        resize(1'b1, 13'd2, 1'b1, 13'h1FFF);
        new_palette();
        rx_max <= 7;
        repeat (40) feed(pick_pixel(), pause_len(7), 1'b0, '0);

        // receiver holds off while back-to-back pixels fill the result queue
        resize(1'b1, 13'd16, 1'b1, 13'd1);
        rx_max   <= 0;
        hold_ask <= hold_ask + 1;
        repeat (32) feed(pick_pixel(), 0, 1'b0, '0);

        // random small frames, mostly whole ones, some cut short by the next write
        fed = 0;
        while (fed < RANDOM_PIXELS) begin
            case ($urandom_range(0, 5))
                0:       w_raw = 13'd0;
                1:       w_raw = 13'd1;
                2:       w_raw = {2'($urandom), 11'($urandom_range(1, 6))};
                default: w_raw = 13'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 5))
                0:       h_raw = 13'd0;
                1:       h_raw = 13'd1;
                2:       h_raw = 13'd2;
                default: h_raw = 13'($urandom_range(1, 6));
            endcase
            which = $urandom_range(0, 3);
            resize(which != 1, w_raw, which != 0, h_raw);
            frame_px = cols_in_use() * rows_in_use();
            n = $urandom_range(1, 3) * frame_px;
            if ($urandom_range(0, 3) == 0) n += $urandom_range(1, frame_px);
            if (n > RANDOM_PIXELS - fed) n = RANDOM_PIXELS - fed;
            tx_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
            rx_max <= ($urandom_range(0, 2) == 0) ? 0 : 7;
            new_palette();
            repeat (n) feed(pick_pixel(), pause_len(tx_max), 1'b0, '0);
            fed += n;
        end

        settle();
        if (mismatches == 0 && blocks_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
